/* design/ffca_pkg.sv */
// Shared constants, types and helpers of the first-fit coalescing allocator.
package ffca_pkg;

	localparam int MAX_SEGMENTS  = 16;
	localparam int GRANULE_BYTES = 64;
	localparam int HEADER_BYTES  = 24;
	localparam int HEAP_BYTES    = 65536;
	localparam int STORE_DEPTH   = HEAP_BYTES / 8;
	localparam int SLOT_W        = $clog2(STORE_DEPTH);
	localparam int SEG_IDX_W     = $clog2(MAX_SEGMENTS);
	localparam int SEG_CNT_W     = $clog2(MAX_SEGMENTS + 1);
	localparam int SIZE_W        = 17;
	localparam int ADDR_W        = 32;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ZERO  = 2'd1;
	localparam logic [1:0] STAT_NOFIT = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	localparam logic [2:0] TOP_NONE   = 3'd0;
	localparam logic [2:0] TOP_INIT   = 3'd1;
	localparam logic [2:0] TOP_SET    = 3'd2;
	localparam logic [2:0] TOP_REMOVE = 3'd3;
	localparam logic [2:0] TOP_INSERT = 3'd4;
	localparam logic [2:0] TOP_JOIN   = 3'd5;

	localparam logic CFG_HEAP_BASE = 1'b0;
	localparam logic CFG_HEAP_SIZE = 1'b1;

	typedef struct packed {
		logic [2:0]           op;
		logic [SEG_IDX_W-1:0] idx;
		logic [ADDR_W-1:0]    addr;
		logic [SIZE_W-1:0]    size;
	} tbl_cmd_t;

	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W+1:0] v);
		if (v > (SIZE_W+2)'({SIZE_W{1'b1}})) begin
			return {SIZE_W{1'b1}};
		end
		return v[SIZE_W-1:0];
	endfunction

endpackage

/* design/ffca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffca_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/ffca_table.sv */
// Address-sorted free-segment table with registered insert and remove shifts.
module ffca_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ffca_pkg::tbl_cmd_t               cmd,
	input  logic [ffca_pkg::SEG_IDX_W-1:0]   rd_idx,
	output logic [ffca_pkg::ADDR_W-1:0]      rd_addr,
	output logic [ffca_pkg::SIZE_W-1:0]      rd_size,
	output logic [ffca_pkg::SEG_CNT_W-1:0]   count
);

	logic [ffca_pkg::ADDR_W-1:0]    addr_q [ffca_pkg::MAX_SEGMENTS];
	logic [ffca_pkg::SIZE_W-1:0]    size_q [ffca_pkg::MAX_SEGMENTS];
	logic [ffca_pkg::SEG_CNT_W-1:0] count_q;

	assign rd_addr = addr_q[rd_idx];
	assign rd_size = size_q[rd_idx];
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ffca_pkg::SEG_CNT_W'(1);
			for (int j = 0; j < ffca_pkg::MAX_SEGMENTS; j++) begin
				addr_q[j] <= '0;
				size_q[j] <= '0;
			end
			size_q[0] <= ffca_pkg::SIZE_W'(ffca_pkg::HEAP_BYTES - ffca_pkg::HEADER_BYTES);
		end else begin
			unique case (cmd.op) inside
				ffca_pkg::TOP_NONE: begin
				end
				ffca_pkg::TOP_INIT: begin
					count_q   <= ffca_pkg::SEG_CNT_W'(1);
					addr_q[0] <= cmd.addr;
					size_q[0] <= cmd.size;
				end
				ffca_pkg::TOP_SET: begin
					addr_q[cmd.idx] <= cmd.addr;
					size_q[cmd.idx] <= cmd.size;
				end
				ffca_pkg::TOP_REMOVE, ffca_pkg::TOP_JOIN: begin
					for (int j = 0; j < ffca_pkg::MAX_SEGMENTS - 1; j++) begin
						if (ffca_pkg::SEG_IDX_W'(j) >= cmd.idx) begin
							addr_q[j] <= addr_q[j+1];
							size_q[j] <= size_q[j+1];
						end
					end
					if (cmd.op == ffca_pkg::TOP_JOIN) begin
						size_q[cmd.idx - ffca_pkg::SEG_IDX_W'(1)] <= cmd.size;
					end
					count_q <= count_q - ffca_pkg::SEG_CNT_W'(1);
				end
				ffca_pkg::TOP_INSERT: begin
					for (int j = 1; j < ffca_pkg::MAX_SEGMENTS; j++) begin
						if (ffca_pkg::SEG_IDX_W'(j) > cmd.idx) begin
							addr_q[j] <= addr_q[j-1];
							size_q[j] <= size_q[j-1];
						end
					end
					addr_q[cmd.idx] <= cmd.addr;
					size_q[cmd.idx] <= cmd.size;
					count_q <= count_q + ffca_pkg::SEG_CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* design/first_fit_coalescing_allocator.sv */
// Top level: sequencer that walks the free-segment table for allocate and free.
// Allocate scans up to 16 entries and commits; free reads the size, scans and merges;
// zero-size requests and frees of address 0 go to done; one entry is read per cycle.
// Throughput: one item at a time; a new item is taken once the result is registered.
// Reset: asynchronous, active low; table holds one segment at heap_base, block
// size store is not cleared (unwritten slots are never read by legal traffic).
module first_fit_coalescing_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [10:0]                   granule_count,
	input  logic [31:0]                   payload_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   result_address,
	output logic [1:0]                    status
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_A_SCAN   = 4'd1;
	localparam logic [3:0] ST_A_COMMIT = 4'd2;
	localparam logic [3:0] ST_F_RD     = 4'd3;
	localparam logic [3:0] ST_F_SZ     = 4'd4;
	localparam logic [3:0] ST_F_SCAN   = 4'd5;
	localparam logic [3:0] ST_F_JOIN   = 4'd6;
	localparam logic [3:0] ST_F_MERGE  = 4'd7;
	localparam logic [3:0] ST_DONE     = 4'd8;

	localparam int AW = ffca_pkg::ADDR_W;
	localparam int SW = ffca_pkg::SIZE_W;
	localparam int SL = ffca_pkg::SLOT_W;

	logic [3:0]                     state_q;
	logic [31:0]                    heap_base_q;
	logic [SW-1:0]                  heap_size_q;
	logic [SW-1:0]                  need_q;
	logic [AW-1:0]                  hdr_q;
	logic [ffca_pkg::SEG_CNT_W-1:0] idx_q;
	logic [AW-1:0]                  prev_addr_q;
	logic [SW-1:0]                  prev_size_q;
	logic [SW-1:0]                  sz_q;
	logic [AW-1:0]                  seg_addr_q;
	logic [SW-1:0]                  seg_size_q;
	logic [SW-1:0]                  rem_q;
	logic                           jn_q;
	logic                           jp_q;
	logic [SW-1:0]                  nxt_size_q;
	logic [AW-1:0]                  res_addr_q;
	logic [1:0]                     res_stat_q;
	logic                           out_valid_q;
	logic [AW-1:0]                  out_addr_q;
	logic [1:0]                     out_stat_q;

	ffca_pkg::tbl_cmd_t             cmd;
	logic [AW-1:0]                  rd_addr;
	logic [SW-1:0]                  rd_size;
	logic [ffca_pkg::SEG_CNT_W-1:0] count;
	logic                           ram_we;
	logic [SL-1:0]                  ram_waddr;
	logic [SW-1:0]                  ram_wdata;
	logic [SL-1:0]                  ram_raddr;
	logic [SW-1:0]                  ram_rdata;
	logic [AW-1:0]                  new_base;
	logic [SW-1:0]                  new_size;
	logic [AW-1:0]                  a_off;
	logic [AW-1:0]                  f_off;
	logic                           small_rem;
	logic                           scan_end;

	ffca_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_idx  (idx_q[ffca_pkg::SEG_IDX_W-1:0]),
		.rd_addr (rd_addr),
		.rd_size (rd_size),
		.count   (count)
	);

	ffca_ram #(
		.WIDTH (SW),
		.DEPTH (ffca_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_stat_q;

	assign a_off     = seg_addr_q - heap_base_q;
	assign f_off     = hdr_q - heap_base_q;
	assign ram_waddr = a_off[SL+2:3];
	assign ram_raddr = f_off[SL+2:3];
	assign ram_we    = (state_q == ST_A_COMMIT);
	assign small_rem = rem_q < SW'(ffca_pkg::GRANULE_BYTES + ffca_pkg::HEADER_BYTES);
	assign ram_wdata = small_rem ? seg_size_q : need_q;
	assign scan_end  = idx_q >= count;

	always_comb begin
		new_base = heap_base_q;
		new_size = heap_size_q;
		if (cfg_index == ffca_pkg::CFG_HEAP_BASE) begin
			new_base = cfg_data;
		end else begin
			new_size = cfg_data[SW-1:0];
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = ffca_pkg::TOP_NONE;
		cmd.idx  = idx_q[ffca_pkg::SEG_IDX_W-1:0];
		if (cfg_we) begin
			cmd.op   = ffca_pkg::TOP_INIT;
			cmd.addr = new_base;
			cmd.size = (new_size > SW'(ffca_pkg::HEADER_BYTES)) ?
				new_size - SW'(ffca_pkg::HEADER_BYTES) : '0;
		end else if (state_q == ST_A_COMMIT) begin
			if (small_rem) begin
				cmd.op = ffca_pkg::TOP_REMOVE;
			end else begin
				cmd.op   = ffca_pkg::TOP_SET;
				cmd.addr = seg_addr_q + AW'(ffca_pkg::HEADER_BYTES) + AW'(need_q);
				cmd.size = rem_q - SW'(ffca_pkg::HEADER_BYTES);
			end
		end else if (state_q == ST_F_MERGE) begin
			if (jn_q && jp_q) begin
				cmd.op   = ffca_pkg::TOP_JOIN;
				cmd.size = ffca_pkg::sat_size((SW+2)'(prev_size_q) +
					(SW+2)'(2 * ffca_pkg::HEADER_BYTES) + (SW+2)'(sz_q) +
					(SW+2)'(nxt_size_q));
			end else if (jp_q) begin
				cmd.op   = ffca_pkg::TOP_SET;
				cmd.idx  = idx_q[ffca_pkg::SEG_IDX_W-1:0] - ffca_pkg::SEG_IDX_W'(1);
				cmd.addr = prev_addr_q;
				cmd.size = ffca_pkg::sat_size((SW+2)'(prev_size_q) +
					(SW+2)'(ffca_pkg::HEADER_BYTES) + (SW+2)'(sz_q));
			end else if (jn_q) begin
				cmd.op   = ffca_pkg::TOP_SET;
				cmd.addr = hdr_q;
				cmd.size = ffca_pkg::sat_size((SW+2)'(sz_q) +
					(SW+2)'(ffca_pkg::HEADER_BYTES) + (SW+2)'(nxt_size_q));
			end else if (count < ffca_pkg::SEG_CNT_W'(ffca_pkg::MAX_SEGMENTS)) begin
				cmd.op   = ffca_pkg::TOP_INSERT;
				cmd.addr = hdr_q;
				cmd.size = sz_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
			heap_size_q <= SW'(ffca_pkg::HEAP_BYTES);
		end else if (cfg_we) begin
			heap_base_q <= new_base;
			heap_size_q <= new_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_addr_q <= '0;
						res_stat_q <= ffca_pkg::STAT_OK;
						idx_q      <= '0;
						need_q     <= SW'(granule_count) * SW'(ffca_pkg::GRANULE_BYTES);
						hdr_q      <= payload_address - AW'(ffca_pkg::HEADER_BYTES);
						if (opcode == 1'b0) begin
							if (granule_count == '0) begin
								res_stat_q <= ffca_pkg::STAT_ZERO;
								state_q    <= ST_DONE;
							end else begin
								state_q <= ST_A_SCAN;
							end
						end else if (payload_address == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_F_RD;
						end
					end
				end
				ST_A_SCAN: begin
					if (scan_end) begin
						res_stat_q <= ffca_pkg::STAT_NOFIT;
						state_q    <= ST_DONE;
					end else if (rd_size >= need_q) begin
						seg_addr_q <= rd_addr;
						seg_size_q <= rd_size;
						rem_q      <= rd_size - need_q;
						state_q    <= ST_A_COMMIT;
					end else begin
						idx_q <= idx_q + ffca_pkg::SEG_CNT_W'(1);
					end
				end
				ST_A_COMMIT: begin
					res_addr_q <= seg_addr_q + AW'(ffca_pkg::HEADER_BYTES);
					state_q    <= ST_DONE;
				end
				ST_F_RD: begin
					state_q <= ST_F_SZ;
				end
				ST_F_SZ: begin
					sz_q    <= ram_rdata;
					state_q <= ST_F_SCAN;
				end
				ST_F_SCAN: begin
					if (scan_end || rd_addr >= hdr_q) begin
						state_q <= ST_F_JOIN;
					end else begin
						prev_addr_q <= rd_addr;
						prev_size_q <= rd_size;
						idx_q       <= idx_q + ffca_pkg::SEG_CNT_W'(1);
					end
				end
				ST_F_JOIN: begin
					jn_q <= !scan_end &&
						(hdr_q + AW'(ffca_pkg::HEADER_BYTES) + AW'(sz_q) == rd_addr);
					jp_q <= (idx_q != '0) &&
						(prev_addr_q + AW'(ffca_pkg::HEADER_BYTES) + AW'(prev_size_q) == hdr_q);
					nxt_size_q <= rd_size;
					state_q    <= ST_F_MERGE;
				end
				ST_F_MERGE: begin
					if (!jn_q && !jp_q &&
						count >= ffca_pkg::SEG_CNT_W'(ffca_pkg::MAX_SEGMENTS)) begin
						res_stat_q <= ffca_pkg::STAT_FULL;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= res_addr_q;
						out_stat_q  <= res_stat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= ffca_pkg::SEG_CNT_W'(ffca_pkg::MAX_SEGMENTS))
		else $error("segment count above table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while previous one in flight");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ffca_pkg::STAT_OK |-> result_address == '0)
		else $error("failed request returned an address");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the first-fit coalescing allocator: directed table, random traffic.
`timescale 1ns / 1ps
module tb_top;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic        op;
		logic [10:0] count;
		logic [31:0] addr;
		bit          typed;
		logic [31:0] want_addr;
		logic [1:0]  want_status;
	} stim_row_t;

	typedef struct {
		logic [31:0] addr;
		logic [1:0]  status;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [10:0] granule_count;
	logic [31:0] payload_address;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_address;
	logic [1:0]  status;

	first_fit_coalescing_allocator uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .granule_count(granule_count),
		.payload_address(payload_address), .out_valid(out_valid),
		.out_ready(out_ready), .result_address(result_address), .status(status)
	);

	// free-segment table mirror
	logic [31:0]                 seg_hdr [ffca_pkg::MAX_SEGMENTS];
	logic [ffca_pkg::SIZE_W-1:0] seg_sz  [ffca_pkg::MAX_SEGMENTS];
	int                          seg_n;
	logic [31:0]                 heap_base_q;
	logic [ffca_pkg::SIZE_W-1:0] heap_size_q;
	logic [ffca_pkg::SIZE_W-1:0] block_sizes [int];
	int                          used_slots[$];
	logic [31:0]                 live_blocks[$];

	alloc_result_t pending_results[$];
	int  mismatches;
	int  idle_cycles;
	int  status_seen [4];
	bit  calm;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic int slot_of(input logic [31:0] hdr);
		logic [31:0] off;
		off = hdr - heap_base_q;
		return int'(off[15:3]);
	endfunction

	function automatic void table_init();
		seg_hdr[0] = heap_base_q;
		seg_sz[0]  = (heap_size_q > ffca_pkg::HEADER_BYTES) ?
			ffca_pkg::SIZE_W'(heap_size_q - ffca_pkg::HEADER_BYTES) : '0;
		seg_n      = 1;
		live_blocks.delete();
	endfunction

	function automatic void table_remove(input int i);
		for (int k = i; k < seg_n - 1; k++) begin
			seg_hdr[k] = seg_hdr[k+1];
			seg_sz[k]  = seg_sz[k+1];
		end
		seg_n--;
	endfunction

	function automatic void table_insert(input int i, input logic [31:0] a,
		input logic [ffca_pkg::SIZE_W-1:0] s);
		for (int k = seg_n; k > i; k--) begin
			seg_hdr[k] = seg_hdr[k-1];
			seg_sz[k]  = seg_sz[k-1];
		end
		seg_hdr[i] = a;
		seg_sz[i]  = s;
		seg_n++;
	endfunction

	function automatic logic [ffca_pkg::SIZE_W-1:0] clamp17(input logic [19:0] v);
		return (v > 20'h1FFFF) ? 17'h1FFFF : v[16:0];
	endfunction

	function automatic void record_size(input logic [31:0] hdr,
		input logic [ffca_pkg::SIZE_W-1:0] s);
		int sl;
		sl = slot_of(hdr);
		if (!block_sizes.exists(sl)) used_slots.push_back(sl);
		block_sizes[sl] = s;
	endfunction

	function automatic alloc_result_t heap_step(input logic op, input logic [10:0] cnt,
		input logic [31:0] addr);
		alloc_result_t r;
		logic [31:0] need, hdr, rem;
		logic [ffca_pkg::SIZE_W-1:0] sz;
		int i, pos;
		bit jn, jp;
		r.addr = '0;
		r.status = ffca_pkg::STAT_OK;
		if (op == 1'b0) begin
			if (cnt == 0) begin
				r.status = ffca_pkg::STAT_ZERO;
				return r;
			end
			need = 32'(cnt) * ffca_pkg::GRANULE_BYTES;
			for (i = 0; i < seg_n; i++) if (32'(seg_sz[i]) >= need) break;
			if (i >= seg_n) begin
				r.status = ffca_pkg::STAT_NOFIT;
				return r;
			end
			hdr = seg_hdr[i];
			rem = 32'(seg_sz[i]) - need;
			if (rem < ffca_pkg::GRANULE_BYTES + ffca_pkg::HEADER_BYTES) begin
				record_size(hdr, seg_sz[i]);
				table_remove(i);
			end else begin
				record_size(hdr, need[16:0]);
				seg_hdr[i] = hdr + ffca_pkg::HEADER_BYTES + need;
				seg_sz[i]  = 17'(rem - ffca_pkg::HEADER_BYTES);
			end
			r.addr = hdr + ffca_pkg::HEADER_BYTES;
			live_blocks.push_back(r.addr);
			return r;
		end
		if (addr == 0) return r;
		hdr = addr - ffca_pkg::HEADER_BYTES;
		sz  = block_sizes[slot_of(hdr)];
		for (pos = 0; pos < seg_n; pos++) if (seg_hdr[pos] >= hdr) break;
		jn = (pos < seg_n) && (hdr + ffca_pkg::HEADER_BYTES + 32'(sz) == seg_hdr[pos]);
		jp = (pos > 0) &&
			(seg_hdr[pos-1] + ffca_pkg::HEADER_BYTES + 32'(seg_sz[pos-1]) == hdr);
		if (jn && jp) begin
			seg_sz[pos-1] = clamp17(20'(20'(seg_sz[pos-1]) + 2*ffca_pkg::HEADER_BYTES
				+ 20'(sz) + 20'(seg_sz[pos])));
			table_remove(pos);
		end else if (jp) begin
			seg_sz[pos-1] = clamp17(20'(20'(seg_sz[pos-1]) + ffca_pkg::HEADER_BYTES
				+ 20'(sz)));
		end else if (jn) begin
			seg_hdr[pos] = hdr;
			seg_sz[pos]  = clamp17(20'(20'(sz) + ffca_pkg::HEADER_BYTES
				+ 20'(seg_sz[pos])));
		end else if (seg_n >= ffca_pkg::MAX_SEGMENTS) begin
			r.status = ffca_pkg::STAT_FULL;
		end else begin
			table_insert(pos, hdr, sz);
		end
		if (r.status == ffca_pkg::STAT_OK) begin
			foreach (live_blocks[k]) if (live_blocks[k] == addr) begin
				live_blocks.delete(k);
				break;
			end
		end
		return r;
	endfunction

	task automatic send_item(input logic op, input logic [10:0] cnt, input logic [31:0] addr,
		input bit typed, input logic [31:0] want_addr, input logic [1:0] want_status);
		alloc_result_t r;
		if (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 27);
		end
		in_valid        <= 1'b1;
		opcode          <= op;
		granule_count   <= cnt;
		payload_address <= addr;
		do @(posedge clk); while (!(in_valid && in_ready));
		r = heap_step(op, cnt, addr);
		if (typed && (r.addr !== want_addr || r.status !== want_status)) begin
			report_mismatch("typed address", r.addr, want_addr);
			report_mismatch("typed status", 32'(r.status), 32'(want_status));
		end
		pending_results.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_heap(input logic [31:0] b, input logic [ffca_pkg::SIZE_W-1:0] s);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= ffca_pkg::CFG_HEAP_BASE;
		cfg_data  <= b;
		@(posedge clk);
		cfg_index <= ffca_pkg::CFG_HEAP_SIZE;
		cfg_data  <= 32'(s);
		@(posedge clk);
		cfg_we    <= 1'b0;
		heap_base_q = b;
		heap_size_q = s;
		table_init();
		@(posedge clk);
	endtask

	task automatic random_item();
		int p;
		logic [31:0] a;
		p = $urandom_range(99);
		if (p < 3) begin
			send_item(1'b0, 11'd0, $urandom, 0, '0, '0);
		end else if (p < 50) begin
			send_item(1'b0, ($urandom_range(9) == 0) ? 11'($urandom_range(1024, 1))
				: 11'($urandom_range(8, 1)), $urandom, 0, '0, '0);
		end else if (p < 88 && live_blocks.size() != 0) begin
			a = live_blocks[$urandom_range(live_blocks.size() - 1)];
			send_item(1'b1, 11'($urandom), a, 0, '0, '0);
		end else if (p < 93 || used_slots.size() == 0) begin
			send_item(1'b1, 11'($urandom), 32'd0, 0, '0, '0);
		end else begin
			// stale or aliased header, random upper bits
			a = heap_base_q + 32'(used_slots[$urandom_range(used_slots.size() - 1)]) * 8
				+ ffca_pkg::HEADER_BYTES + ($urandom << 16) + $urandom_range(7);
			send_item(1'b1, 11'($urandom), a, 0, '0, '0);
		end
	endtask

	task automatic fragment_heap();
		logic [31:0] grabbed[$];
		for (int k = 0; k < 36; k++) begin
			send_item(1'b0, 11'd1, $urandom, 0, '0, '0);
			if (live_blocks.size() != 0) grabbed.push_back(live_blocks[$]);
		end
		for (int k = 0; k < grabbed.size(); k += 2)
			send_item(1'b1, 11'($urandom), grabbed[k], 0, '0, '0);
	endtask

	task automatic run_phase(input int n);
		for (int k = 0; k < n; k++) begin
			calm = (k >= 100 && k < 220);
			if (k % 160 == 80) fragment_heap();
			else random_item();
			if (k == n / 2) drain();
		end
		calm = 1'b0;
	endtask

	stim_row_t directed[$];

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 27);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", result_address, '0);
				end else begin
					if (result_address !== pending_results[0].addr)
						report_mismatch("result_address", result_address,
							pending_results[0].addr);
					if (status !== pending_results[0].status)
						report_mismatch("status", 32'(status),
							32'(pending_results[0].status));
					status_seen[pending_results[0].status]++;
					void'(pending_results.pop_front());
				end
			end
		end
	end

	initial begin
		cfg_we          <= 1'b0;
		cfg_index       <= ffca_pkg::CFG_HEAP_BASE;
		cfg_data        <= '0;
		in_valid        <= 1'b0;
		opcode          <= 1'b0;
		granule_count   <= '0;
		payload_address <= '0;
		arst_n          <= 1'b0;
		mismatches  = 0;
		idle_cycles = 0;
		calm        = 1'b0;
		heap_base_q = '0;
		heap_size_q = 17'd65536;
		table_init();
		directed = '{
			'{1'b0, 11'd0,    32'h0,        1, 32'h0,  ffca_pkg::STAT_ZERO},
			'{1'b0, 11'd1,    32'hFFFFFFFF, 1, 32'd24, ffca_pkg::STAT_OK},
			'{1'b0, 11'd1024, 32'h0,        1, 32'h0,  ffca_pkg::STAT_NOFIT},
			'{1'b1, 11'h7FF,  32'h0,        1, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b0, 11'd2,    32'h0,        0, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b0, 11'd3,    32'h0,        0, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b0, 11'd1022, 32'h0,        0, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b1, 11'd0,    32'd24,       0, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b1, 11'd0,    32'd24,       0, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b0, 11'd1,    32'h0,        0, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b1, 11'd0,    32'd112,      0, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b1, 11'd0,    32'd264,      0, 32'h0,  ffca_pkg::STAT_OK},
			'{1'b0, 11'd1024, 32'h0,        0, 32'h0,  ffca_pkg::STAT_OK}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k])
			send_item(directed[k].op, directed[k].count, directed[k].addr, directed[k].typed,
				directed[k].want_addr, directed[k].want_status);
		fragment_heap();
		set_heap(32'h0, 17'd65536);
		run_phase(340);
		set_heap(32'hFFFFF000, 17'd65536);
		run_phase(280);
		set_heap($urandom & 32'hFFFFFFF8, 17'd65536);
		run_phase(230);
		set_heap($urandom, 17'd3000);
		run_phase(140);
		set_heap($urandom, 17'd20);
		run_phase(60);
		set_heap(32'hFFFFFFFF, 17'd0);
		run_phase(60);
		set_heap($urandom, 17'd65536);
		run_phase(110);
		drain();
		$display("covered: %0d ok, %0d zero-size, %0d no-fit, %0d table-full results",
			status_seen[ffca_pkg::STAT_OK], status_seen[ffca_pkg::STAT_ZERO],
			status_seen[ffca_pkg::STAT_NOFIT], status_seen[ffca_pkg::STAT_FULL]);
		$display("heap settings: base 0 / wrap / random, size 65536 down to 0");
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/ffca_pkg.sv
design/ffca_ram.sv
design/ffca_table.sv
design/first_fit_coalescing_allocator.sv
tb/tb_top.sv
